/* hw/rtl/dpst_pkg.sv */
// Shared types and constants for the dual pedal sensor throttle block.
// Holds controller/datapath command and status structs, check limits and codes.
// No dependencies.
`default_nettype none

package dpst_pkg;

	// Internal arithmetic widths
	localparam int TH_W        = 16;            // threshold arithmetic wraps here
	localparam int QUO_W       = 10;            // quotient bits (max 999)
	localparam int IDX_W       = $clog2(QUO_W); // quotient bit index
	localparam int REM_W       = TH_W + QUO_W;  // dividend / remainder width
	localparam int PROD_W      = 32;            // reciprocal product width
	localparam int RECIP_SHIFT = 19;
	localparam int TIME_W      = 32;

	// Output field widths
	localparam int MEAN_W = 12;
	localparam int PCT_W  = 7;
	localparam int PM_W   = 10;
	localparam int KIND_W = 2;

	// Config port
	localparam int CFG_IDX_W  = 2;
	localparam int PMAX_RESET = 4095;

	localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 2'd2;

	// Fault kinds
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DISAGREE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RANGE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SHORTED  = 2'd3;

	// Limits and scale factors
	localparam logic [TH_W-1:0]   LOW_VALID   = 16'd50;
	localparam logic [TH_W-1:0]   HIGH_VALID  = 16'd4050;
	localparam logic [TH_W-1:0]   SHORT_LIMIT = 16'd10;
	localparam logic [TH_W-1:0]   RECIP_DIV10 = 16'd52429; // ceil(2^19 / 10)
	localparam logic [TIME_W-1:0] TIMEOUT_MS  = 32'd100;
	localparam logic [QUO_W-1:0]  PCT_MUL     = 10'd100;
	localparam logic [QUO_W-1:0]  PM_MUL      = 10'd999;
	localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
	localparam logic [PM_W-1:0]   PM_MAX      = 10'd999;
	localparam logic [IDX_W-1:0]  QUO_LAST    = IDX_W'(QUO_W - 1);

	// Controller -> datapath commands
	typedef struct packed {
		logic             load_in;
		logic             prep;
		logic             mul;
		logic             classify;
		logic             div_step;
		logic [IDX_W-1:0] step_idx;
		logic             out_load;
	} dp_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic timed_out;
		logic in_band;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/dpst_dp.sv */
// Datapath: config registers, sample capture, plausibility checks, fault timer,
// reciprocal multiply, two-lane restoring divider and output register.
// Depends on dpst_pkg.
`default_nettype none

module dpst_dp #(
	parameter int SENSOR_BITS = 12
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [dpst_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire [SENSOR_BITS-1:0]             cfg_data,
	input  wire [SENSOR_BITS-1:0]             first_sensor,
	input  wire [SENSOR_BITS-1:0]             second_sensor,
	input  wire [dpst_pkg::TIME_W-1:0]        time_ms,
	input  dpst_pkg::dp_cmd_t                 cmd,
	output dpst_pkg::dp_sts_t                 sts,
	input  wire                               out_ready,
	output logic                              out_valid,
	output logic [dpst_pkg::PCT_W-1:0]        throttle_percent,
	output logic [dpst_pkg::PM_W-1:0]         throttle_permille,
	output logic [dpst_pkg::MEAN_W-1:0]       sensor_mean,
	output logic                              fault,
	output logic [dpst_pkg::KIND_W-1:0]       fault_kind
);

	localparam int TH_W  = dpst_pkg::TH_W;
	localparam int REM_W = dpst_pkg::REM_W;
	localparam int QUO_W = dpst_pkg::QUO_W;

	// config registers
	logic [SENSOR_BITS-1:0] pedal_min_q, pedal_max_q;
	logic [SENSOR_BITS-2:0] dead_band_q;

	// item registers
	logic [SENSOR_BITS-1:0]          s1_q, s2_q, mean_q;
	logic [dpst_pkg::TIME_W-1:0]     time_q;
	logic [TH_W-1:0]                 lo_q, hi_q, span_q, diff_q;
	logic [dpst_pkg::PROD_W-1:0]     lim_prod_q;
	logic [REM_W-1:0]                rem_pct_q, rem_pm_q;
	logic [QUO_W-1:0]                q_pct_q, q_pm_q;

	// fault state
	logic                            fault_pending_q, timed_out_q;
	logic [dpst_pkg::TIME_W-1:0]     fault_start_q;
	logic [dpst_pkg::KIND_W-1:0]     latched_kind_q;

	logic                            out_valid_q;

	// combinational
	logic [SENSOR_BITS:0]            mean_sum;
	logic [TH_W-1:0]                 lo_next, hi_next;
	logic [TH_W-1:0]                 s1_ext, s2_ext, half_ext, mean_ext;
	logic [TH_W-1:0]                 ad_half, ad_raw, lim;
	logic [dpst_pkg::KIND_W-1:0]     kind;
	logic [dpst_pkg::TIME_W-1:0]     elapsed;
	logic [REM_W-1:0]                dsh;
	logic                            pct_ge, pm_ge;
	logic                            mean_le_lo, mean_ge_hi;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedal_min_q <= '0;
			pedal_max_q <= SENSOR_BITS'(dpst_pkg::PMAX_RESET);
			dead_band_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dpst_pkg::REG_PEDAL_MIN: pedal_min_q <= cfg_data;
				dpst_pkg::REG_PEDAL_MAX: pedal_max_q <= cfg_data;
				dpst_pkg::REG_DEAD_BAND: dead_band_q <= cfg_data[SENSOR_BITS-2:0];
				default: ;
			endcase
		end
	end

	// thresholds and mean at capture
	assign mean_sum = {1'b0, first_sensor} + {2'b00, second_sensor[SENSOR_BITS-1:1]};
	assign lo_next  = TH_W'(pedal_min_q) + TH_W'(dead_band_q);
	assign hi_next  = TH_W'(pedal_max_q) - TH_W'(dead_band_q);

	assign s1_ext   = TH_W'(s1_q);
	assign s2_ext   = TH_W'(s2_q);
	assign half_ext = TH_W'(s2_q[SENSOR_BITS-1:1]);
	assign mean_ext = TH_W'(mean_q);

	// plausibility checks, first failing one wins
	assign ad_half = (s1_ext > half_ext) ? s1_ext - half_ext : half_ext - s1_ext;
	assign ad_raw  = (s1_ext > s2_ext) ? s1_ext - s2_ext : s2_ext - s1_ext;
	assign lim     = TH_W'(lim_prod_q >> dpst_pkg::RECIP_SHIFT);

	always_comb begin
		if (ad_half > lim) begin
			kind = dpst_pkg::KIND_DISAGREE;
		end else if (s1_ext < dpst_pkg::LOW_VALID || s2_ext < dpst_pkg::LOW_VALID ||
				s1_ext > dpst_pkg::HIGH_VALID || s2_ext > dpst_pkg::HIGH_VALID) begin
			kind = dpst_pkg::KIND_RANGE;
		end else if (ad_raw < dpst_pkg::SHORT_LIMIT) begin
			kind = dpst_pkg::KIND_SHORTED;
		end else begin
			kind = dpst_pkg::KIND_NONE;
		end
	end

	assign elapsed    = time_q - fault_start_q;
	assign mean_le_lo = (mean_ext <= lo_q);
	assign mean_ge_hi = (mean_ext >= hi_q);

	// divider step: both lanes share the shifted divisor
	assign dsh    = REM_W'(span_q) << cmd.step_idx;
	assign pct_ge = (rem_pct_q >= dsh);
	assign pm_ge  = (rem_pm_q >= dsh);

	// item datapath
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			s1_q   <= first_sensor;
			s2_q   <= second_sensor;
			time_q <= time_ms;
			mean_q <= mean_sum[SENSOR_BITS:1];
			lo_q   <= lo_next;
			hi_q   <= hi_next;
		end
		if (cmd.prep) begin
			span_q <= hi_q - lo_q;
			diff_q <= mean_ext - lo_q;
		end
		if (cmd.mul) begin
			lim_prod_q <= dpst_pkg::PROD_W'(span_q) *
				dpst_pkg::PROD_W'(dpst_pkg::RECIP_DIV10);
			rem_pct_q  <= REM_W'(diff_q) * REM_W'(dpst_pkg::PCT_MUL);
			rem_pm_q   <= REM_W'(diff_q) * REM_W'(dpst_pkg::PM_MUL);
			q_pct_q    <= '0;
			q_pm_q     <= '0;
		end
		if (cmd.div_step) begin
			if (pct_ge) begin
				rem_pct_q              <= rem_pct_q - dsh;
				q_pct_q[cmd.step_idx]  <= 1'b1;
			end
			if (pm_ge) begin
				rem_pm_q               <= rem_pm_q - dsh;
				q_pm_q[cmd.step_idx]   <= 1'b1;
			end
		end
	end

	// fault latch and timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_pending_q <= 1'b0;
			fault_start_q   <= '0;
			latched_kind_q  <= dpst_pkg::KIND_NONE;
			timed_out_q     <= 1'b0;
		end else if (cmd.classify) begin
			if (kind != dpst_pkg::KIND_NONE) begin
				if (!fault_pending_q) begin
					fault_pending_q <= 1'b1;
					fault_start_q   <= time_q;
					latched_kind_q  <= kind;
					timed_out_q     <= 1'b0;
				end else begin
					timed_out_q <= (elapsed > dpst_pkg::TIMEOUT_MS);
				end
			end else begin
				fault_pending_q <= 1'b0;
				latched_kind_q  <= dpst_pkg::KIND_NONE;
				timed_out_q     <= 1'b0;
			end
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (timed_out_q) begin
				throttle_percent  <= '0;
				throttle_permille <= '0;
				sensor_mean       <= '0;
				fault             <= 1'b1;
				fault_kind        <= latched_kind_q;
			end else begin
				sensor_mean <= mean_ext[dpst_pkg::MEAN_W-1:0];
				fault       <= 1'b0;
				fault_kind  <= dpst_pkg::KIND_NONE;
				if (mean_le_lo) begin
					throttle_percent  <= '0;
					throttle_permille <= '0;
				end else if (mean_ge_hi) begin
					throttle_percent  <= dpst_pkg::PCT_MAX;
					throttle_permille <= dpst_pkg::PM_MAX;
				end else begin
					throttle_percent  <= (q_pct_q > QUO_W'(dpst_pkg::PCT_MAX)) ?
						dpst_pkg::PCT_MAX : q_pct_q[dpst_pkg::PCT_W-1:0];
					throttle_permille <= (q_pm_q > dpst_pkg::PM_MAX) ?
						dpst_pkg::PM_MAX : q_pm_q;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.timed_out = timed_out_q;
	assign sts.in_band   = !mean_le_lo && !mean_ge_hi;
	assign sts.out_busy  = out_valid_q && !out_ready;

endmodule

`default_nettype wire

/* hw/rtl/dpst_ctrl.sv */
// Controller: sequences capture, threshold prep, multiply, checks, divide and
// output load for one sample at a time. Depends on dpst_pkg.
`default_nettype none

module dpst_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  dpst_pkg::dp_sts_t sts,
	output dpst_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_CLASS,
		S_CHECK,
		S_DIV,
		S_FIN
	} state_t;

	state_t                        state_q;
	logic [dpst_pkg::IDX_W-1:0]    cnt_q;

	// state and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PREP;
				end
				S_PREP:  state_q <= S_MUL;
				S_MUL:   state_q <= S_CLASS;
				S_CLASS: state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.timed_out || !sts.in_band) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
						cnt_q   <= dpst_pkg::QUO_LAST;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					if (!sts.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	assign in_ready     = (state_q == S_IDLE);
	assign cmd.load_in  = in_ready && in_valid;
	assign cmd.prep     = (state_q == S_PREP);
	assign cmd.mul      = (state_q == S_MUL);
	assign cmd.classify = (state_q == S_CLASS);
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.step_idx = cnt_q;
	assign cmd.out_load = (state_q == S_FIN) && !sts.out_busy;

endmodule

`default_nettype wire

/* hw/rtl/dual_pedal_sensor_throttle_top.sv */
// Per beat: capture, threshold prep, multiply, classify and check, then output load;
// when the mean is inside both thresholds and no fault timed out, both quotients are
// first made by a 10-step restoring divider, one quotient bit per cycle, two lanes.
// One beat at a time; the next beat is taken while a result waits.
// Reset (arst_n, async low): pedal_min 0, pedal_max 4095, dead_band 0, fault
// state cleared, no result pending.
`default_nettype none

module dual_pedal_sensor_throttle_top #(
	parameter int SENSOR_BITS = 12
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [dpst_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire [SENSOR_BITS-1:0]           cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [SENSOR_BITS-1:0]           first_sensor,
	input  wire [SENSOR_BITS-1:0]           second_sensor,
	input  wire [dpst_pkg::TIME_W-1:0]      time_ms,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [dpst_pkg::PCT_W-1:0]      throttle_percent,
	output logic [dpst_pkg::PM_W-1:0]       throttle_permille,
	output logic [dpst_pkg::MEAN_W-1:0]     sensor_mean,
	output logic                            fault,
	output logic [dpst_pkg::KIND_W-1:0]     fault_kind
);

	dpst_pkg::dp_cmd_t cmd;
	dpst_pkg::dp_sts_t sts;

	dpst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dpst_dp #(
		.SENSOR_BITS (SENSOR_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_data          (cfg_data),
		.first_sensor      (first_sensor),
		.second_sensor     (second_sensor),
		.time_ms           (time_ms),
		.cmd               (cmd),
		.sts               (sts),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.throttle_percent  (throttle_percent),
		.throttle_permille (throttle_permille),
		.sensor_mean       (sensor_mean),
		.fault             (fault),
		.fault_kind        (fault_kind)
	);

endmodule

`default_nettype wire
